/* design/strided_conv_bias_relu_q8_8_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the convolution engine
// Shorthand for clocked implications checked under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef STRIDED_CONV_BIAS_RELU_Q8_8_CORE_ASSERT_SVH
`define STRIDED_CONV_BIAS_RELU_Q8_8_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCBR_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/scbr_pkg.sv */
// ----------------------------------------------------------------------------
// scbr_pkg
// Dimensions, derived widths, command codes and shared types of the
// strided convolution engine.
// ----------------------------------------------------------------------------
package scbr_pkg;

  localparam int IN_CHANNELS  = 3;
  localparam int IMAGE_SIZE   = 227;
  localparam int OUT_CHANNELS = 96;
  localparam int KERNEL_SIZE  = 11;
  localparam int STRIDE_STEP  = 4;

  localparam int OUT_SIZE     = (IMAGE_SIZE - KERNEL_SIZE) / STRIDE_STEP + 1;
  localparam int KAREA        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int TAPS         = IN_CHANNELS * KAREA;
  localparam int PLANE        = IMAGE_SIZE * IMAGE_SIZE;
  localparam int WEIGHT_DEPTH = OUT_CHANNELS * TAPS;
  localparam int IMAGE_DEPTH  = IN_CHANNELS * PLANE;
  localparam int ROW_STEP     = STRIDE_STEP * IMAGE_SIZE;

  localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int IAW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
  localparam int BAW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int CHW = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int KW  = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;

  // Command queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_BIAS   = 2'd1,
    CMD_LOAD_PIXEL  = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            kind;
    logic [IAW-1:0]  pix_addr;   // pixel address, or window origin for a compute
    logic [WAW-1:0]  wgt_addr;   // weight address, or kernel base for a compute
    logic [BAW-1:0]  bias_addr;
    logic [15:0]     value;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } bstate_e;

endpackage

/* design/scbr_front.sv */
// ----------------------------------------------------------------------------
// scbr_front
// Accepts command words, drops those with out-of-range indices and turns
// the rest into queue entries with flat memory addresses.
// ----------------------------------------------------------------------------
module scbr_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [1:0]        in_channel_i,
  input  logic [3:0]        kernel_row_i,
  input  logic [3:0]        kernel_col_i,
  input  logic [6:0]        out_channel_i,
  input  logic [7:0]        pixel_row_i,
  input  logic [7:0]        pixel_col_i,
  input  logic [5:0]        out_row_i,
  input  logic [5:0]        out_col_i,
  input  logic signed [15:0] load_value_i,
  input  scbr_pkg::qstat_t  qstat_i,
  output logic              push_o,
  output scbr_pkg::qitem_t  item_o
);
  import scbr_pkg::*;

  cmd_e kind;
  logic ic_ok, kr_ok, kc_ok, oc_ok, pr_ok, pc_ok, or_ok, ocl_ok;
  logic keep;

  assign kind   = cmd_e'(command_i);
  assign ic_ok  = int'(in_channel_i) < IN_CHANNELS;
  assign kr_ok  = int'(kernel_row_i) < KERNEL_SIZE;
  assign kc_ok  = int'(kernel_col_i) < KERNEL_SIZE;
  assign oc_ok  = int'(out_channel_i) < OUT_CHANNELS;
  assign pr_ok  = int'(pixel_row_i) < IMAGE_SIZE;
  assign pc_ok  = int'(pixel_col_i) < IMAGE_SIZE;
  assign or_ok  = int'(out_row_i) < OUT_SIZE;
  assign ocl_ok = int'(out_col_i) < OUT_SIZE;

  always_comb begin
    unique case (kind)
      CMD_LOAD_WEIGHT: keep = oc_ok && ic_ok && kr_ok && kc_ok;
      CMD_LOAD_BIAS:   keep = oc_ok;
      CMD_LOAD_PIXEL:  keep = ic_ok && pr_ok && pc_ok;
      CMD_COMPUTE:     keep = oc_ok && or_ok && ocl_ok;
      default:         keep = 1'b0;
    endcase
  end

  always_comb begin
    item_o.kind      = kind;
    item_o.value     = load_value_i;
    item_o.bias_addr = BAW'(out_channel_i);
    if (kind == CMD_COMPUTE) begin
      item_o.wgt_addr = WAW'(int'(out_channel_i) * TAPS);
      item_o.pix_addr = IAW'(int'(out_row_i) * ROW_STEP + int'(out_col_i) * STRIDE_STEP);
    end else begin
      item_o.wgt_addr = WAW'(int'(out_channel_i) * TAPS + int'(in_channel_i) * KAREA
                             + int'(kernel_row_i) * KERNEL_SIZE + int'(kernel_col_i));
      item_o.pix_addr = IAW'(int'(in_channel_i) * PLANE + int'(pixel_row_i) * IMAGE_SIZE
                             + int'(pixel_col_i));
    end
  end

  // Dropped words are still consumed; they simply never reach the queue.
  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full && keep;

endmodule

/* design/scbr_fifo.sv */
// ----------------------------------------------------------------------------
// scbr_fifo
// Short command queue that decouples the decode front from the MAC back.
// ----------------------------------------------------------------------------
module scbr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scbr_pkg::qitem_t item_i,
  input  logic             pop_i,
  output scbr_pkg::qitem_t item_o,
  output scbr_pkg::qstat_t qstat_o
);
  import scbr_pkg::*;

  qitem_t         entry_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign qstat_o.full  = cnt_q == (QAW+1)'(QDEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign item_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/scbr_back.sv */
// ----------------------------------------------------------------------------
// scbr_back
// Owns the weight, bias and image memories, performs loads and runs the
// shared multiply-accumulate over every tap of a compute request.
// ----------------------------------------------------------------------------
`include "strided_conv_bias_relu_q8_8_core_assert.svh"

module scbr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scbr_pkg::qstat_t qstat_i,
  input  scbr_pkg::qitem_t item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [14:0]      feature_value_o
);
  import scbr_pkg::*;

  logic [15:0] weight_mem [WEIGHT_DEPTH];
  logic [15:0] image_mem  [IMAGE_DEPTH];
  logic [15:0] bias_mem   [OUT_CHANNELS];

  bstate_e state_q, state_d;

  logic           pop, start, wr_w, wr_b, wr_p, issue, out_load, last_tap;
  logic [BAW-1:0] bias_addr_q;
  logic [WAW-1:0] w_addr_q;
  logic [IAW-1:0] p_addr_q, row_base_q, chan_base_q;
  logic [CHW-1:0] ch_q;
  logic [KW-1:0]  kr_q, kc_q;
  logic [15:0]    w_rd_q, p_rd_q, bias_rd_q;
  logic           rd_vld_q, prod_vld_q;
  logic signed [31:0] prod_q;
  logic [15:0]    sum_q;
  logic           out_valid_q;
  logic [14:0]    out_value_q;

  assign last_tap = (ch_q == CHW'(IN_CHANNELS - 1)) && (kr_q == KW'(KERNEL_SIZE - 1))
                    && (kc_q == KW'(KERNEL_SIZE - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty && item_i.kind == CMD_COMPUTE) begin
          state_d = ST_BIAS;
        end
      end
      ST_BIAS:  state_d = ST_INIT;
      ST_INIT:  state_d = ST_RUN;
      ST_RUN: begin
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = (state_q == ST_IDLE) && !qstat_i.empty;
    start    = pop && (item_i.kind == CMD_COMPUTE);
    wr_w     = pop && (item_i.kind == CMD_LOAD_WEIGHT);
    wr_b     = pop && (item_i.kind == CMD_LOAD_BIAS);
    wr_p     = pop && (item_i.kind == CMD_LOAD_PIXEL);
    issue    = state_q == ST_RUN;
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tap walk: weights are contiguous per output channel, pixels advance
  // along a row, then to the next image row, then to the next channel plane.
  always_ff @(posedge clk_i) begin
    if (start) begin
      bias_addr_q <= item_i.bias_addr;
      w_addr_q    <= item_i.wgt_addr;
      p_addr_q    <= item_i.pix_addr;
      row_base_q  <= item_i.pix_addr;
      chan_base_q <= item_i.pix_addr;
      ch_q        <= '0;
      kr_q        <= '0;
      kc_q        <= '0;
    end else if (issue) begin
      w_addr_q <= w_addr_q + 1'b1;
      if (kc_q == KW'(KERNEL_SIZE - 1)) begin
        kc_q <= '0;
        if (kr_q == KW'(KERNEL_SIZE - 1)) begin
          kr_q        <= '0;
          ch_q        <= ch_q + 1'b1;
          chan_base_q <= chan_base_q + IAW'(PLANE);
          row_base_q  <= chan_base_q + IAW'(PLANE);
          p_addr_q    <= chan_base_q + IAW'(PLANE);
        end else begin
          kr_q       <= kr_q + 1'b1;
          row_base_q <= row_base_q + IAW'(IMAGE_SIZE);
          p_addr_q   <= row_base_q + IAW'(IMAGE_SIZE);
        end
      end else begin
        kc_q     <= kc_q + 1'b1;
        p_addr_q <= p_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_w) begin
      weight_mem[item_i.wgt_addr] <= item_i.value;
    end
    w_rd_q <= weight_mem[w_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_p) begin
      image_mem[item_i.pix_addr] <= item_i.value;
    end
    p_rd_q <= image_mem[p_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      bias_mem[item_i.bias_addr] <= item_i.value;
    end
    bias_rd_q <= bias_mem[bias_addr_q];
  end

  // Adding the product's bits 23:8 equals floor-truncating the Q16.16 sum
  // back to Q8.8 and wrapping to 16 bits.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(w_rd_q) * $signed(p_rd_q);
    if (state_q == ST_INIT) begin
      sum_q <= bias_rd_q;
    end else if (prod_vld_q) begin
      sum_q <= sum_q + prod_q[23:8];
    end
    if (out_load) begin
      out_value_q <= sum_q[15] ? '0 : sum_q[14:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign feature_value_o = out_value_q;

  `SCBR_ASSERT_NEXT(a_pipe_advance, rd_vld_q, prod_vld_q, "read data did not reach the multiplier")
  `SCBR_ASSERT_HOLD(a_done_drained, state_q == ST_DONE, !rd_vld_q && !prod_vld_q, "result taken before the pipeline drained")
  `SCBR_ASSERT_HOLD(a_pop_nonempty, pop, !qstat_i.empty, "popped an empty queue")
  `SCBR_ASSERT_NEXT(a_run_end, state_q == ST_RUN && last_tap, state_q == ST_DRAIN, "tap walk overran the kernel")

endmodule

/* design/strided_conv_bias_relu_q8_8_core.sv */
// ----------------------------------------------------------------------------
// strided_conv_bias_relu_q8_8_core
// Convolution layer engine with bias and ReLU in signed Q8.8.
// ----------------------------------------------------------------------------
// Usage: command words enter on the in_valid_i / in_ready_o channel. Load
// commands write a weight, bias or pixel into internal memory and produce no
// output word; a compute command produces one feature word on the
// out_valid_o / out_ready_i channel. Words with out-of-range indices are
// consumed and ignored. Words are carried out strictly in arrival order, so a
// compute sees every load accepted before it.
// Throughput: the back end applies a load as it pops it. A compute runs one
// multiply-accumulate per cycle over 363 taps (3 channels of 11 by 11) and
// holds the back end through the bias fetch, the tap walk and the pipeline
// drain, taking no new word until its result is loaded for output; the single
// shared multiplier and the one read port of each memory set that rate.
// A four-word queue lets the input keep accepting while the back end works.
// Reset clears the queue and the control state; memory contents stay
// undefined until written. If the receiver stalls, the result waits in the
// output register and the back end holds the next result until it is taken.
module strided_conv_bias_relu_q8_8_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [1:0]         in_channel_i,
  input  logic [3:0]         kernel_row_i,
  input  logic [3:0]         kernel_col_i,
  input  logic [6:0]         out_channel_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [7:0]         pixel_col_i,
  input  logic [5:0]         out_row_i,
  input  logic [5:0]         out_col_i,
  input  logic signed [15:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        feature_value_o
);
  import scbr_pkg::*;

  qstat_t qstat;
  qitem_t push_item, head_item;
  logic   push, pop;

  scbr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .in_channel_i  (in_channel_i),
    .kernel_row_i  (kernel_row_i),
    .kernel_col_i  (kernel_col_i),
    .out_channel_i (out_channel_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .out_row_i     (out_row_i),
    .out_col_i     (out_col_i),
    .load_value_i  (load_value_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  scbr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  scbr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .item_i          (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .feature_value_o (feature_value_o)
  );

endmodule

/* tb/scbr_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scbr_tb_pkg
// Command word type and feature scoreboard for the convolution engine
// testbench. The scoreboard keeps its own copy of the weight, bias and image
// memories, predicts every feature word and checks what the engine returns.
// ----------------------------------------------------------------------------
package scbr_tb_pkg;

  import scbr_pkg::*;

  typedef struct {
    cmd_e               command;
    logic [1:0]         in_channel;
    logic [3:0]         kernel_row;
    logic [3:0]         kernel_col;
    logic [6:0]         out_channel;
    logic [7:0]         pixel_row;
    logic [7:0]         pixel_col;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [15:0] load_value;
  } cmd_word_t;

  class feature_board;

    logic [15:0] weights     [WEIGHT_DEPTH];
    logic [15:0] biases      [OUT_CHANNELS];
    logic [15:0] pixels      [IMAGE_DEPTH];
    bit          weight_seen [WEIGHT_DEPTH];
    bit          bias_seen   [OUT_CHANNELS];
    bit          pixel_seen  [IMAGE_DEPTH];
    logic [14:0] expected_features [$];
    int          errors;
    int          checked;
    int          predicted;
    int          loads;
    int          ignored;

    function int weight_index(int oc, int ch, int kr, int kc);
      return ((oc * IN_CHANNELS + ch) * KERNEL_SIZE + kr) * KERNEL_SIZE + kc;
    endfunction

    function int pixel_index(int ch, int row, int col);
      return (ch * IMAGE_SIZE + row) * IMAGE_SIZE + col;
    endfunction

    function int pending();
      return expected_features.size();
    endfunction

    // True when the bias, every weight of the channel and every pixel under
    // the window have been loaded since reset.
    function bit window_written(int oc, int orow, int ocol);
      if (!bias_seen[oc]) return 1'b0;
      for (int ch = 0; ch < IN_CHANNELS; ch++) begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
          for (int c = 0; c < KERNEL_SIZE; c++) begin
            if (!weight_seen[weight_index(oc, ch, r, c)] ||
                !pixel_seen[pixel_index(ch, orow * STRIDE_STEP + r,
                                        ocol * STRIDE_STEP + c)]) return 1'b0;
          end
        end
      end
      return 1'b1;
    endfunction

    function void note_word(cmd_word_t w);
      int      idx;
      shortint acc;
      shortint wv;
      shortint pv;
      longint  wide;
      case (w.command)
        CMD_LOAD_WEIGHT: begin
          if (w.out_channel < OUT_CHANNELS && w.in_channel < IN_CHANNELS &&
              w.kernel_row < KERNEL_SIZE && w.kernel_col < KERNEL_SIZE) begin
            idx = weight_index(w.out_channel, w.in_channel, w.kernel_row, w.kernel_col);
            weights[idx]     = w.load_value;
            weight_seen[idx] = 1'b1;
            loads++;
          end else begin
            ignored++;
          end
        end
        CMD_LOAD_BIAS: begin
          if (w.out_channel < OUT_CHANNELS) begin
            biases[w.out_channel]    = w.load_value;
            bias_seen[w.out_channel] = 1'b1;
            loads++;
          end else begin
            ignored++;
          end
        end
        CMD_LOAD_PIXEL: begin
          if (w.in_channel < IN_CHANNELS && w.pixel_row < IMAGE_SIZE &&
              w.pixel_col < IMAGE_SIZE) begin
            idx = pixel_index(w.in_channel, w.pixel_row, w.pixel_col);
            pixels[idx]     = w.load_value;
            pixel_seen[idx] = 1'b1;
            loads++;
          end else begin
            ignored++;
          end
        end
        default: begin
          if (w.out_channel < OUT_CHANNELS && w.out_row < OUT_SIZE &&
              w.out_col < OUT_SIZE) begin
            acc = biases[w.out_channel];
            for (int ch = 0; ch < IN_CHANNELS; ch++) begin
              for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                  wv = weights[weight_index(w.out_channel, ch, r, c)];
                  pv = pixels[pixel_index(ch, w.out_row * STRIDE_STEP + r,
                                          w.out_col * STRIDE_STEP + c)];
                  // Q8.8 sum aligned to the Q16.16 product; bits 23:8 give the
                  // floor to Q8.8, wrapped to 16 bits.
                  wide = longint'(acc) * 256 + longint'(pv) * longint'(wv);
                  acc  = wide[23:8];
                end
              end
            end
            expected_features.push_back((acc > 0) ? acc[14:0] : 15'd0);
            predicted++;
          end else begin
            ignored++;
          end
        end
      endcase
    endfunction

    function void check_feature(logic [14:0] got);
      logic [14:0] want;
      if (expected_features.size() == 0) begin
        $display("%0t: unexpected feature word: expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = expected_features.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: feature_value mismatch: expected %0d (0x%04h), got %0d (0x%04h)",
                 $time, want, want, got, got);
        errors++;
      end
    endfunction

  endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads two output channels' biases, then their full weights and two image
// regions in shuffled order, then mixes compute words over those windows
// with rewrites, fresh loads and out-of-range words. Both channels idle at
// random and the receiver once holds off long enough to back the engine up.
// ----------------------------------------------------------------------------
module testbench;

  import scbr_pkg::*;
  import scbr_tb_pkg::*;

  localparam int HOLD_CYCLES  = 4000;
  localparam int HANG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int LIVE_WORDS   = 1650;
  localparam int MIN_FEATURES = 60;
  localparam int CORNER       = (OUT_SIZE - 1) * STRIDE_STEP;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         command_i;
  logic [1:0]         in_channel_i;
  logic [3:0]         kernel_row_i;
  logic [3:0]         kernel_col_i;
  logic [6:0]         out_channel_i;
  logic [7:0]         pixel_row_i;
  logic [7:0]         pixel_col_i;
  logic [5:0]         out_row_i;
  logic [5:0]         out_col_i;
  logic signed [15:0] load_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [14:0]        feature_value_o;

  feature_board board;
  int           sender_calm;

  strided_conv_bias_relu_q8_8_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'($urandom);
    if (roll < 85) return 16'($urandom_range(0, 1023) - 512);
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'h0100;
      default: return 16'hFF00;
    endcase
  endfunction

  // Fields that the command does not use carry random bits.
  function automatic cmd_word_t random_word(cmd_e kind);
    cmd_word_t w;
    w.command     = kind;
    w.in_channel  = 2'($urandom);
    w.kernel_row  = 4'($urandom);
    w.kernel_col  = 4'($urandom);
    w.out_channel = 7'($urandom);
    w.pixel_row   = 8'($urandom);
    w.pixel_col   = 8'($urandom);
    w.out_row     = 6'($urandom);
    w.out_col     = 6'($urandom);
    w.load_value  = pick_value();
    return w;
  endfunction

  function automatic cmd_word_t weight_word(int oc, int ch, int kr, int kc);
    cmd_word_t w;
    w             = random_word(CMD_LOAD_WEIGHT);
    w.out_channel = 7'(oc);
    w.in_channel  = 2'(ch);
    w.kernel_row  = 4'(kr);
    w.kernel_col  = 4'(kc);
    return w;
  endfunction

  function automatic cmd_word_t pixel_word(int ch, int row, int col);
    cmd_word_t w;
    w            = random_word(CMD_LOAD_PIXEL);
    w.in_channel = 2'(ch);
    w.pixel_row  = 8'(row);
    w.pixel_col  = 8'(col);
    return w;
  endfunction

  function automatic cmd_word_t bias_word(int oc);
    cmd_word_t w;
    w             = random_word(CMD_LOAD_BIAS);
    w.out_channel = 7'(oc);
    return w;
  endfunction

  function automatic cmd_word_t compute_word(int oc, int row, int col);
    cmd_word_t w;
    w             = random_word(CMD_COMPUTE);
    w.out_channel = 7'(oc);
    w.out_row     = 6'(row);
    w.out_col     = 6'(col);
    return w;
  endfunction

  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= w.command;
    in_channel_i  <= w.in_channel;
    kernel_row_i  <= w.kernel_row;
    kernel_col_i  <= w.kernel_col;
    out_channel_i <= w.out_channel;
    pixel_row_i   <= w.pixel_row;
    pixel_col_i   <= w.pixel_col;
    out_row_i     <= w.out_row;
    out_col_i     <= w.out_col;
    load_value_i  <= w.load_value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(w);
  endtask

  // Stimulus and end of run.
  initial begin
    cmd_word_t fill [$];
    cmd_word_t w;
    int        pick;
    int        roll;
    int        oc_pick;
    board         = new();
    sender_calm   = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_LOAD_WEIGHT;
    in_channel_i  <= '0;
    kernel_row_i  <= '0;
    kernel_col_i  <= '0;
    out_channel_i <= '0;
    pixel_row_i   <= '0;
    pixel_col_i   <= '0;
    out_row_i     <= '0;
    out_col_i     <= '0;
    load_value_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Each of these words has at least one index past its dimension and is dropped.
    for (int n = 0; n < 13; n++) begin
      case (n)
        0:  begin w = random_word(CMD_LOAD_WEIGHT); w.in_channel = 2'd3; end
        1:  begin w = random_word(CMD_LOAD_WEIGHT); w.kernel_row = 4'(KERNEL_SIZE); end
        2:  begin w = random_word(CMD_LOAD_WEIGHT); w.kernel_col = 4'hF; end
        3:  begin w = random_word(CMD_LOAD_WEIGHT); w.out_channel = 7'h7F; end
        4:  begin w = random_word(CMD_LOAD_BIAS); w.out_channel = 7'(OUT_CHANNELS); end
        5:  begin w = random_word(CMD_LOAD_BIAS); w.out_channel = 7'h7F; end
        6:  begin w = random_word(CMD_LOAD_PIXEL); w.in_channel = 2'd3; end
        7:  begin w = random_word(CMD_LOAD_PIXEL); w.pixel_row = 8'(IMAGE_SIZE); end
        8:  begin w = random_word(CMD_LOAD_PIXEL); w.pixel_col = 8'hFF; end
        9:  w = compute_word(OUT_CHANNELS, 0, 0);
        10: w = compute_word(0, OUT_SIZE, 0);
        11: w = compute_word(OUT_CHANNELS - 1, 0, 63);
        default: w = compute_word(127, 63, 63);
      endcase
      send_word(w);
    end

    w = bias_word(0);
    w.load_value = 16'sh7FFF;
    send_word(w);
    w = bias_word(OUT_CHANNELS - 1);
    w.load_value = 16'sh8000;
    send_word(w);

    // Both extreme output channels, the top-left windows and the far corner.
    for (int ch = 0; ch < IN_CHANNELS; ch++) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE + STRIDE_STEP; c++) begin
          fill.push_back(pixel_word(ch, r, c));
          if (c < KERNEL_SIZE) begin
            fill.push_back(weight_word(0, ch, r, c));
            fill.push_back(weight_word(OUT_CHANNELS - 1, ch, r, c));
            fill.push_back(pixel_word(ch, CORNER + r, CORNER + c));
          end
        end
      end
    end
    for (int i = fill.size() - 1; i > 0; i--) begin
      pick       = $urandom_range(0, i);
      w          = fill[i];
      fill[i]    = fill[pick];
      fill[pick] = w;
    end
    foreach (fill[i]) send_word(fill[i]);

    for (int k = 0; k < 2; k++) begin
      oc_pick = (k == 0) ? 0 : OUT_CHANNELS - 1;
      send_word(compute_word(oc_pick, 0, 0));
      send_word(compute_word(oc_pick, 0, 1));
      send_word(compute_word(oc_pick, OUT_SIZE - 1, OUT_SIZE - 1));
    end

    while (board.loads + board.predicted < LIVE_WORDS || board.predicted < MIN_FEATURES) begin
      roll    = $urandom_range(0, 99);
      oc_pick = ($urandom_range(0, 1) == 1) ? OUT_CHANNELS - 1 : 0;
      if (roll < 40) begin
        case ($urandom_range(0, 2))
          0:       w = compute_word(oc_pick, 0, 0);
          1:       w = compute_word(oc_pick, 0, 1);
          default: w = compute_word(oc_pick, OUT_SIZE - 1, OUT_SIZE - 1);
        endcase
      end else if (roll < 70) begin
        // Rewrite a live entry so that later computes see the new value.
        case ($urandom_range(0, 2))
          0: w = weight_word(oc_pick, $urandom_range(0, IN_CHANNELS - 1),
                             $urandom_range(0, KERNEL_SIZE - 1),
                             $urandom_range(0, KERNEL_SIZE - 1));
          1: begin
            if ($urandom_range(0, 1) == 1) begin
              w = pixel_word($urandom_range(0, IN_CHANNELS - 1),
                             $urandom_range(0, KERNEL_SIZE - 1),
                             $urandom_range(0, KERNEL_SIZE + STRIDE_STEP - 1));
            end else begin
              w = pixel_word($urandom_range(0, IN_CHANNELS - 1),
                             CORNER + $urandom_range(0, KERNEL_SIZE - 1),
                             CORNER + $urandom_range(0, KERNEL_SIZE - 1));
            end
          end
          default: w = bias_word(oc_pick);
        endcase
      end else if (roll < 85) begin
        case ($urandom_range(0, 2))
          0: w = weight_word($urandom_range(0, OUT_CHANNELS - 1),
                             $urandom_range(0, IN_CHANNELS - 1),
                             $urandom_range(0, KERNEL_SIZE - 1),
                             $urandom_range(0, KERNEL_SIZE - 1));
          1: w = pixel_word($urandom_range(0, IN_CHANNELS - 1),
                            $urandom_range(0, IMAGE_SIZE - 1),
                            $urandom_range(0, IMAGE_SIZE - 1));
          default: w = bias_word($urandom_range(0, OUT_CHANNELS - 1));
        endcase
      end else begin
        // Unconstrained word; a compute over an unloaded window is pushed
        // out of range so that no undefined memory entry is ever read.
        w = random_word(cmd_e'($urandom_range(0, 3)));
        if (w.command == CMD_COMPUTE && w.out_channel < OUT_CHANNELS &&
            w.out_row < OUT_SIZE && w.out_col < OUT_SIZE &&
            !board.window_written(w.out_channel, w.out_row, w.out_col)) begin
          w.out_row = 6'(OUT_SIZE + $urandom_range(0, 63 - OUT_SIZE));
        end
      end
      send_word(w);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d loads and %0d dropped out-of-range words applied, %0d features checked.",
             board.loads, board.ignored, board.checked);
    $display("Summary: receiver stalled at random and once for %0d cycles with the engine backed up.",
             HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once results flow.
  initial begin
    int gap;
    int calm;
    bit held;
    calm        = 0;
    held        = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && board.checked >= 8) begin
        held        = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap(calm);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_feature(feature_value_o);
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: timeout, no word accepted for %0d cycles", $time, HANG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
